// ===== hw/rtl/jsc_pkg.sv =====
`timescale 1ns / 1ps

package jsc_pkg;

  localparam int unsigned CoefW  = 32;
  localparam int unsigned SfW    = 16;
  localparam int unsigned CbW    = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NormW  = 5;   // redundant sign bit count, 0..31
  localparam int unsigned ShiftW = 16;  // net shift n + e, signed

  localparam int unsigned FracBits = 16;  // product scaling
  localparam int unsigned ExpBias  = 2;   // exponent offset of the scalefactor
  localparam int unsigned SfIdxW   = 2;   // scalefactor bits picking a table word

  // intensity codebooks, lower and upper
  localparam logic [CbW-1:0] CbIntensityLo = 4'd14;
  localparam logic [CbW-1:0] CbIntensityHi = 4'd15;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_DELAY  = 3'd0,
    CFG_NEGATE_SF  = 3'd1,
    CFG_SCALE_W0   = 3'd2,
    CFG_SCALE_W1   = 3'd3,
    CFG_SCALE_W2   = 3'd4,
    CFG_SCALE_W3   = 3'd5
  } cfg_idx_e;

  // operands handed to the intensity scaler
  typedef struct packed {
    logic signed [CoefW-1:0] left;
    logic                    ms;
    logic                    cb_lsb;
    logic signed [SfW-1:0]   sf;
  } is_req_t;

  typedef logic signed [CoefW-1:0] scale_tbl_t [2**SfIdxW];

endpackage

// ===== hw/rtl/jsc_intensity_scaler.sv =====
`timescale 1ns / 1ps

// Intensity right-channel scaler: 3 register stages, result combinational
// off the last stage.
module jsc_intensity_scaler (
  input  logic                                clk_i,
  input  jsc_pkg::is_req_t                    req_i,
  input  logic                                negate_sf_i,
  input  jsc_pkg::scale_tbl_t                 scale_word_i,
  output logic signed [jsc_pkg::CoefW-1:0]    right_o
);
  import jsc_pkg::*;

  localparam logic signed [CoefW-1:0] Max32 = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] Min32 = {1'b1, {(CoefW-1){1'b0}}};

  // stage 1: scalefactor, table word, normalisation count
  logic signed [SfW:0]        f;
  logic signed [SfW-2:0]      f_div4;
  logic signed [ShiftW-1:0]   e_d;
  logic signed [CoefW-1:0]    w_sel, w_d;
  logic        [CoefW-1:0]    mag;
  logic        [NormW-1:0]    n_d;

  logic signed [CoefW-1:0]    left_s1_q, w_s1_q;
  logic        [NormW-1:0]    n_s1_q;
  logic signed [ShiftW-1:0]   e_s1_q;

  always_comb begin
    f      = negate_sf_i ? -{req_i.sf[SfW-1], req_i.sf} : {req_i.sf[SfW-1], req_i.sf};
    f_div4 = f[SfW:SfIdxW];
    e_d    = -ShiftW'(f_div4) - ShiftW'(ExpBias);
    w_sel  = scale_word_i[f[SfIdxW-1:0]];
    w_d    = (req_i.ms == req_i.cb_lsb) ? -w_sel : w_sel;
    mag    = req_i.left[CoefW-1] ? ~req_i.left : req_i.left;
    n_d    = NormW'(CoefW - 1);
    for (int i = 0; i < CoefW - 1; i++) begin
      if (mag[i]) n_d = NormW'(CoefW - 2 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    left_s1_q <= req_i.left;
    w_s1_q    <= w_d;
    n_s1_q    <= n_d;
    e_s1_q    <= e_d;
  end

  // stage 2: normalised operand and net shift
  logic signed [CoefW-1:0]  x_s2_q, w_s2_q;
  logic signed [ShiftW-1:0] s_s2_q;

  always_ff @(posedge clk_i) begin
    x_s2_q <= left_s1_q <<< n_s1_q;
    w_s2_q <= w_s1_q;
    s_s2_q <= e_s1_q + ShiftW'(n_s1_q);
  end

  // stage 3: 32x32 product, keep bits 47..16
  logic signed [2*CoefW-1:0] prod;
  logic signed [CoefW-1:0]   p_s3_q;
  logic signed [ShiftW-1:0]  s_s3_q;

  assign prod = x_s2_q * w_s2_q;

  always_ff @(posedge clk_i) begin
    p_s3_q <= prod[FracBits +: CoefW];
    s_s3_q <= s_s2_q;
  end

  // output: shift back by the net exponent, saturating on left shifts
  logic signed [ShiftW-1:0]  k;
  logic signed [2*CoefW-1:0] wide_shl;
  logic signed [CoefW-1:0]   sat_val;

  always_comb begin
    k        = -s_s3_q;
    wide_shl = {{CoefW{p_s3_q[CoefW-1]}}, p_s3_q} <<< k[NormW-1:0];
    sat_val  = p_s3_q[CoefW-1] ? Min32 : Max32;
    if (s_s3_q[ShiftW-1]) begin
      if (p_s3_q == '0) begin
        right_o = '0;
      end else if (k >= ShiftW'(CoefW)) begin
        right_o = sat_val;
      end else if (wide_shl[2*CoefW-1:CoefW-1] != {(CoefW+1){wide_shl[CoefW-1]}}) begin
        right_o = sat_val;
      end else begin
        right_o = wide_shl[CoefW-1:0];
      end
    end else if (s_s3_q >= ShiftW'(CoefW)) begin
      right_o = {CoefW{p_s3_q[CoefW-1]}};
    end else begin
      right_o = p_s3_q >>> s_s3_q[NormW-1:0];
    end
  end

endmodule

// ===== hw/rtl/joint_stereo_coefficient_unit.sv =====
`timescale 1ns / 1ps

// Joint-stereo coefficient unit. One left/right coefficient beat is taken on
// every clock at which start_i is high; busy_o is always low, so the unit
// never refuses a beat. Each beat returns one processed pair on
// left_out_o/right_out_o, flagged by done_o for a single cycle, in order,
// after it passes the intensity path: sign normalisation, operand shift and
// the 32x32 multiply each sit in their own register stage, and the
// saturating exponent shift feeds the output register. The receiver cannot
// stall the results. The user must write configuration (cfg_we_i/cfg_idx_i/
// cfg_wdata_i) only while no beat is in flight; the unit itself does not
// enforce this. Writes to unused indexes are ignored.
module joint_stereo_coefficient_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [jsc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [jsc_pkg::CoefW-1:0]           cfg_wdata_i,
  // command
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                mode_i,
  input  logic signed [jsc_pkg::CoefW-1:0]    left_coef_i,
  input  logic signed [jsc_pkg::CoefW-1:0]    right_coef_i,
  input  logic                                ms_used_i,
  input  logic [jsc_pkg::CbW-1:0]             band_codebook_i,
  input  logic signed [jsc_pkg::SfW-1:0]      band_scalefactor_i,
  // result
  output logic                                done_o,
  output logic signed [jsc_pkg::CoefW-1:0]    left_out_o,
  output logic signed [jsc_pkg::CoefW-1:0]    right_out_o
);
  import jsc_pkg::*;

  localparam int unsigned Depth = 3;  // register stages inside the scaler

  localparam logic signed [CoefW-1:0] Max32 = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0] Min32 = {1'b1, {(CoefW-1){1'b0}}};

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic       low_delay_q, negate_sf_q;
  scale_tbl_t scale_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_delay_q  <= 1'b0;
      negate_sf_q  <= 1'b0;
      scale_word_q <= '{default: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_DELAY: low_delay_q     <= cfg_wdata_i[0];
        CFG_NEGATE_SF: negate_sf_q     <= cfg_wdata_i[0];
        CFG_SCALE_W0:  scale_word_q[0] <= cfg_wdata_i;
        CFG_SCALE_W1:  scale_word_q[1] <= cfg_wdata_i;
        CFG_SCALE_W2:  scale_word_q[2] <= cfg_wdata_i;
        CFG_SCALE_W3:  scale_word_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Every cycle can take a beat.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---------------------------------------------------------------------
  // Entry: M/S sum/difference and intensity decision
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic                    use_is;   // right output comes from the scaler
    logic signed [CoefW-1:0] left;
    logic signed [CoefW-1:0] right;
  } side_t;

  logic signed [CoefW:0] sum, diff;
  logic                  is_cb;
  side_t                 side_d;

  always_comb begin
    sum  = {left_coef_i[CoefW-1], left_coef_i} + {right_coef_i[CoefW-1], right_coef_i};
    diff = {left_coef_i[CoefW-1], left_coef_i} - {right_coef_i[CoefW-1], right_coef_i};
    // low-delay objects only allow the two top codebooks, which a 4-bit
    // codebook cannot exceed anyway
    is_cb = low_delay_q ? (band_codebook_i == CbIntensityLo ||
                           band_codebook_i == CbIntensityHi)
                        : (band_codebook_i >= CbIntensityLo);

    side_d.use_is = mode_i && is_cb;
    side_d.left   = left_coef_i;
    side_d.right  = right_coef_i;
    if (!mode_i && ms_used_i) begin
      if (sum[CoefW] != sum[CoefW-1]) begin
        side_d.left = sum[CoefW] ? Min32 : Max32;
      end else begin
        side_d.left = sum[CoefW-1:0];
      end
      if (diff[CoefW] != diff[CoefW-1]) begin
        side_d.right = diff[CoefW] ? Min32 : Max32;
      end else begin
        side_d.right = diff[CoefW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Intensity scaler
  // ---------------------------------------------------------------------
  is_req_t                 is_req;
  logic signed [CoefW-1:0] is_right;

  assign is_req.left   = left_coef_i;
  assign is_req.ms     = ms_used_i;
  assign is_req.cb_lsb = band_codebook_i[0];
  assign is_req.sf     = band_scalefactor_i;

  jsc_intensity_scaler u_scaler (
    .clk_i        (clk_i),
    .req_i        (is_req),
    .negate_sf_i  (negate_sf_q),
    .scale_word_i (scale_word_q),
    .right_o      (is_right)
  );

  // ---------------------------------------------------------------------
  // Side pipe, aligned with the scaler stages
  // ---------------------------------------------------------------------
  logic [Depth-1:0] side_valid_q;
  side_t            side_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_valid_q <= '0;
    end else begin
      side_valid_q <= {side_valid_q[Depth-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < Depth; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic                    done_q;
  logic signed [CoefW-1:0] left_out_q, right_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= side_valid_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    left_out_q  <= side_q[Depth-1].left;
    right_out_q <= side_q[Depth-1].use_is ? is_right : side_q[Depth-1].right;
  end

  assign done_o      = done_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;

endmodule

// ===== tb/joint_stereo_coefficient_unit_test.sv =====
`timescale 1ns / 1ps

module joint_stereo_coefficient_unit_test;
  import jsc_pkg::*;

  // Spare cycles at the end catch any stray done_o.
  localparam int unsigned TailCycles = 8;
  localparam int unsigned RandPhases = 7;
  localparam int unsigned PhaseBeats = 250;

  localparam logic signed [CoefW-1:0] CoefMax = 32'sh7fff_ffff;
  localparam logic signed [CoefW-1:0] CoefMin = 32'sh8000_0000;

  // indexes the unit has no register behind
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;

  typedef struct {
    logic                    mode;
    logic signed [CoefW-1:0] left;
    logic signed [CoefW-1:0] right;
    logic                    ms;
    logic [CbW-1:0]          cb;
    logic signed [SfW-1:0]   sf;
  } coef_beat_t;

  typedef struct {
    logic signed [CoefW-1:0] left;
    logic signed [CoefW-1:0] right;
  } coef_pair_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [CoefW-1:0]        cfg_wdata_i;
  logic                    start_i;
  logic                    busy_o;
  logic                    mode_i;
  logic signed [CoefW-1:0] left_coef_i;
  logic signed [CoefW-1:0] right_coef_i;
  logic                    ms_used_i;
  logic [CbW-1:0]          band_codebook_i;
  logic signed [SfW-1:0]   band_scalefactor_i;
  logic                    done_o;
  logic signed [CoefW-1:0] left_out_o;
  logic signed [CoefW-1:0] right_out_o;

  // Mirror of the register file, updated on each write the unit takes.
  logic       low_delay_cfg = 1'b0;
  logic       negate_sf_cfg = 1'b0;
  scale_tbl_t scale_words   = '{default: '0};

  coef_pair_t pending_pairs[$];   // processed pairs still owed by the unit
  int         mismatches = 0;
  bit         no_idle    = 1'b0;  // set for the stretch without gaps

  joint_stereo_coefficient_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .mode_i            (mode_i),
    .left_coef_i       (left_coef_i),
    .right_coef_i      (right_coef_i),
    .ms_used_i         (ms_used_i),
    .band_codebook_i   (band_codebook_i),
    .band_scalefactor_i(band_scalefactor_i),
    .done_o            (done_o),
    .left_out_o        (left_out_o),
    .right_out_o       (right_out_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic signed [CoefW-1:0] sat32(longint v);
    if (v > longint'(CoefMax)) return CoefMax;
    if (v < longint'(CoefMin)) return CoefMin;
    return v[CoefW-1:0];
  endfunction

  // Joint-stereo processing of one beat, in wide signed arithmetic.
  function automatic coef_pair_t process_pair(coef_beat_t b);
    coef_pair_t              r;
    logic                    is_cb;
    logic signed [CoefW-1:0] word;
    logic signed [CoefW-1:0] norm;
    logic signed [CoefW-1:0] prod32;
    logic [CoefW-1:0]        mag;
    longint                  f, e, prod, p, s, k;
    int                      n;
    r.left  = b.left;
    r.right = b.right;
    if (b.mode == 1'b0) begin
      if (b.ms) begin
        r.left  = sat32(longint'(b.left) + longint'(b.right));
        r.right = sat32(longint'(b.left) - longint'(b.right));
      end
    end else begin
      // low-delay objects only take the two top codebooks as intensity
      is_cb = low_delay_cfg ? (b.cb == CbIntensityLo || b.cb == CbIntensityHi)
                            : (b.cb >= CbIntensityLo);
      if (is_cb) begin
        f    = negate_sf_cfg ? -longint'(b.sf) : longint'(b.sf);
        word = scale_words[f[SfIdxW-1:0]];
        // 32-bit negation: the most negative word wraps onto itself
        if (b.ms == b.cb[0]) word = -word;
        e = -((f >>> SfIdxW) + longint'(ExpBias));
        mag = b.left[CoefW-1] ? ~b.left : b.left;
        if (mag == '0) begin
          n = CoefW - 1;
        end else begin
          n = 0;
          while (!mag[CoefW-2]) begin
            mag = mag << 1;
            n++;
          end
        end
        norm   = b.left <<< n;
        prod   = longint'(norm) * longint'(word);
        prod32 = prod[FracBits +: CoefW];   // bits 47..16 kept, so big products wrap
        p      = longint'(prod32);
        s      = longint'(n) + e;
        if (s < 0) begin
          k = -s;
          if (p == 0)       r.right = '0;
          else if (k >= 32) r.right = (p > 0) ? CoefMax : CoefMin;
          else              r.right = sat32(p <<< k);
        end else if (s >= 32) begin
          r.right = (p < 0) ? '1 : '0;
        end else begin
          r.right = prod32 >>> s;
        end
      end
    end
    return r;
  endfunction

  function automatic coef_beat_t make_beat(logic mode, logic signed [CoefW-1:0] left,
                                           logic signed [CoefW-1:0] right, logic ms,
                                           logic [CbW-1:0] cb, logic signed [SfW-1:0] sf);
    coef_beat_t b;
    b.mode  = mode;
    b.left  = left;
    b.right = right;
    b.ms    = ms;
    b.cb    = cb;
    b.sf    = sf;
    return b;
  endfunction

  // Coefficients with a spread of redundant sign bits and the odd extreme.
  function automatic logic signed [CoefW-1:0] rand_coef();
    logic signed [CoefW-1:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(4))
          0:       v = CoefMax;
          1:       v = CoefMin;
          2:       v = '0;
          3:       v = '1;
          default: v = 1;
        endcase
      end
      1, 2:    v = v >>> $urandom_range(CoefW - 1);
      default: ;
    endcase
    return v;
  endfunction

  // One beat on the command port; start_i stays high into the next beat unless
  // idle cycles are drawn, each with a 27 in 100 chance.
  task automatic send_beat(input coef_beat_t b);
    mode_i             <= b.mode;
    left_coef_i        <= b.left;
    right_coef_i       <= b.right;
    ms_used_i          <= b.ms;
    band_codebook_i    <= b.cb;
    band_scalefactor_i <= b.sf;
    start_i            <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_pairs.push_back(process_pair(b));
    while (!no_idle && $urandom_range(99) < 27) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stop issuing and let every outstanding pair come back.
  task automatic settle();
    start_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LOW_DELAY: low_delay_cfg  = data[0];
      CFG_NEGATE_SF: negate_sf_cfg  = data[0];
      CFG_SCALE_W0:  scale_words[0] = data;
      CFG_SCALE_W1:  scale_words[1] = data;
      CFG_SCALE_W2:  scale_words[2] = data;
      CFG_SCALE_W3:  scale_words[3] = data;
      default:       ;
    endcase
  endtask

  // Full register load while the pipe is empty, plus a write to a hole in
  // the index map that must change nothing.
  task automatic set_config(input logic [CoefW-1:0] ld_word, input logic [CoefW-1:0] neg_word,
                            input scale_tbl_t words);
    settle();
    write_reg(CFG_LOW_DELAY, ld_word);
    write_reg(CFG_NEGATE_SF, neg_word);
    for (int i = 0; i < 4; i++) write_reg(CfgIdxW'(CFG_SCALE_W0 + i), words[i]);
    write_reg($urandom_range(1) ? CfgUnusedHi : CfgUnusedLo, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  // Sum and difference saturation both ways, and the flag-clear pass.
  task automatic test_mid_side();
    set_config('0, '0, '{default: '0});
    send_beat(make_beat(1'b0, CoefMax, CoefMax, 1'b1, 4'd0, 16'sd0));
    send_beat(make_beat(1'b0, CoefMin, CoefMin, 1'b1, CbIntensityHi, 16'sh8000));
    send_beat(make_beat(1'b0, CoefMin, CoefMax, 1'b1, 4'd7, 16'sd3));
    send_beat(make_beat(1'b0, CoefMax, CoefMin, 1'b1, 4'd1, -16'sd1));
    send_beat(make_beat(1'b0, CoefMax, CoefMin, 1'b0, CbIntensityLo, 16'sd5));
    send_beat(make_beat(1'b0, 32'sh1234_5678, -32'sh0fed_cba9, 1'b1, 4'd9, 16'sh7fff));
  endtask

  // Intensity path with plain scalefactors: the wrapping table negation, huge
  // shifts either way, zero and minus one on the left, and codebooks that do
  // not select intensity.
  task automatic test_intensity_scaling();
    set_config('0, '0, '{32'h8000_0000, 32'h7fff_ffff, 32'h5a82_799a, 32'hc000_0000});
    send_beat(make_beat(1'b1, CoefMax, 32'sh1111, 1'b0, CbIntensityLo, 16'sd0));
    send_beat(make_beat(1'b1, CoefMin, 32'sd7, 1'b1, CbIntensityHi, 16'sd0));
    send_beat(make_beat(1'b1, 32'sd1, 32'sd9, 1'b0, CbIntensityHi, 16'sh7fff));
    send_beat(make_beat(1'b1, -32'sd12345, 32'sd3, 1'b1, CbIntensityLo, 16'sh8000));
    send_beat(make_beat(1'b1, 32'sd0, 32'sd5, 1'b0, CbIntensityLo, 16'sd1));
    send_beat(make_beat(1'b1, -32'sd1, 32'sd5, 1'b1, CbIntensityHi, 16'sd2));
    send_beat(make_beat(1'b1, 32'sh0001_2345, 32'sd0, 1'b0, CbIntensityHi, 16'sd3));
    send_beat(make_beat(1'b1, 32'sh7654_3210, 32'sd1, 1'b1, CbIntensityLo, -16'sd9));
    send_beat(make_beat(1'b1, 32'sh0000_0100, 32'sd2, 1'b0, 4'd13, 16'sd4));
    send_beat(make_beat(1'b1, CoefMin, CoefMax, 1'b1, 4'd0, -16'sd1));
  endtask

  // Low-delay object with negated scalefactors; the most negative
  // scalefactor negates to a positive 32768.
  task automatic test_low_delay_negated();
    set_config('1, 32'h0000_0003, '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff});
    send_beat(make_beat(1'b1, 32'sh4000_0000, 32'sd1, 1'b0, CbIntensityLo, 16'sh8000));
    send_beat(make_beat(1'b1, -32'sh4000_0000, 32'sd1, 1'b1, CbIntensityHi, 16'sd5));
    send_beat(make_beat(1'b1, 32'sh0000_7fff, 32'sd0, 1'b0, CbIntensityHi, -16'sd7));
    send_beat(make_beat(1'b1, 32'sh0000_abcd, 32'sd4, 1'b1, 4'd12, 16'sd0));
  endtask

  // Random beats over several register settings; most intensity beats carry
  // an intensity codebook and a scalefactor near the useful shift range.
  task automatic test_random_stream();
    coef_beat_t b;
    scale_tbl_t words;
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: set_config('0, '0, '{default: CoefMax});
        1: set_config('1, '1, '{default: CoefMin});
        default: begin
          for (int i = 0; i < 4; i++) begin
            words[i] = $urandom;
            if ($urandom_range(3) == 0) words[i] = $urandom_range(1) ? CoefMax : CoefMin;
          end
          set_config($urandom, $urandom, words);
        end
      endcase
      no_idle = (ph == 3);  // back-to-back beats for one whole phase
      for (int i = 0; i < PhaseBeats; i++) begin
        b.mode  = 1'($urandom_range(1));
        b.left  = rand_coef();
        b.right = rand_coef();
        b.ms    = 1'($urandom_range(1));
        if (b.mode && $urandom_range(9) < 6) b.cb = CbIntensityLo | CbW'($urandom_range(1));
        else                                 b.cb = CbW'($urandom);
        case ($urandom_range(9))
          0:       b.sf = SfW'($urandom);
          1:       b.sf = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          default: b.sf = SfW'($signed($urandom_range(280)) - 140);
        endcase
        send_beat(b);
      end
    end
    no_idle = 1'b0;
  endtask

  // Every done_o beat is checked against the oldest outstanding pair.
  always @(posedge clk_i) begin : result_check
    coef_pair_t want;
    if (rst_ni && done_o) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result: left_out %0d right_out %0d", left_out_o, right_out_o);
        mismatches++;
      end else begin
        want = pending_pairs.pop_front();
        if (left_out_o !== want.left) begin
          $error("left_out: expected %0d, got %0d", want.left, left_out_o);
          mismatches++;
        end
        if (right_out_o !== want.right) begin
          $error("right_out: expected %0d, got %0d", want.right, right_out_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_wdata_i        = '0;
    start_i            = 1'b0;
    mode_i             = 1'b0;
    left_coef_i        = '0;
    right_coef_i       = '0;
    ms_used_i          = 1'b0;
    band_codebook_i    = '0;
    band_scalefactor_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_mid_side();
    test_intensity_scaling();
    test_low_delay_negated();
    test_random_stream();

    settle();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("joint_stereo_coefficient_unit_test: PASS");
    end else begin
      $display("joint_stereo_coefficient_unit_test: FAIL");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("joint_stereo_coefficient_unit_test: FAIL");
    $finish;
  end

endmodule
